@@ rtl/sbc_pkg.sv @@
// Shared types, constants and variant tables for the Simon block cipher.
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned WIDTH_W   = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VARIANT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd4;

  localparam logic [3:0] LAST_VARIANT = 4'd9;

  // Round constant before masking to the word width
  localparam logic [WORD_W-1:0] ROUND_CONST = 64'hFFFF_FFFF_FFFF_FFFC;

  // z-sequences, bit i used at schedule step i mod 62
  localparam logic [WORD_W-1:0] ZSEQ [5] = '{
    64'h19C3_522F_B386_A45F,
    64'h1686_4FB8_AD0C_9F71,
    64'h3369_F885_192C_0EF5,
    64'h3C2C_E512_07A6_35DB,
    64'h3DC9_4C3A_046D_678B
  };
  localparam logic [5:0] ZSEQ_LAST = 6'd61;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCHED,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] in_first;
    logic [WORD_W-1:0] in_second;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_first;
    logic [WORD_W-1:0] out_second;
  } out_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [WIDTH_W-1:0] rounds;
    logic [2:0]         kwords;
    logic [2:0]         zsel;
  } variant_t;

  function automatic variant_t variant_info(input logic [3:0] v);
    variant_t r;
    unique case (v)
      4'd0:    r = '{width: 7'd16, rounds: 7'd32, kwords: 3'd4, zsel: 3'd0};
      4'd1:    r = '{width: 7'd24, rounds: 7'd36, kwords: 3'd3, zsel: 3'd0};
      4'd2:    r = '{width: 7'd24, rounds: 7'd36, kwords: 3'd4, zsel: 3'd1};
      4'd3:    r = '{width: 7'd32, rounds: 7'd42, kwords: 3'd3, zsel: 3'd2};
      4'd4:    r = '{width: 7'd32, rounds: 7'd44, kwords: 3'd4, zsel: 3'd3};
      4'd5:    r = '{width: 7'd48, rounds: 7'd52, kwords: 3'd2, zsel: 3'd2};
      4'd6:    r = '{width: 7'd48, rounds: 7'd54, kwords: 3'd3, zsel: 3'd3};
      4'd7:    r = '{width: 7'd64, rounds: 7'd68, kwords: 3'd2, zsel: 3'd2};
      4'd8:    r = '{width: 7'd64, rounds: 7'd69, kwords: 3'd3, zsel: 3'd3};
      4'd9:    r = '{width: 7'd64, rounds: 7'd72, kwords: 3'd4, zsel: 3'd4};
      default: r = '{width: 7'd64, rounds: 7'd72, kwords: 3'd4, zsel: 3'd4};
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    logic [WORD_W-1:0] m;
    unique case (w)
      7'd16:   m = 64'h0000_0000_0000_FFFF;
      7'd24:   m = 64'h0000_0000_00FF_FFFF;
      7'd32:   m = 64'h0000_0000_FFFF_FFFF;
      7'd48:   m = 64'h0000_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Rotate left by a constant amount within the active word width
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned r,
                                             input logic [WIDTH_W-1:0] w);
    logic [WORD_W-1:0] o;
    unique case (w)
      7'd16:   o = (v << r) | (v >> (16 - r));
      7'd24:   o = (v << r) | (v >> (24 - r));
      7'd32:   o = (v << r) | (v >> (32 - r));
      7'd48:   o = (v << r) | (v >> (48 - r));
      default: o = (v << r) | (v >> (64 - r));
    endcase
    return o & width_mask(w);
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                             input int unsigned r,
                                             input logic [WIDTH_W-1:0] w);
    logic [WORD_W-1:0] o;
    unique case (w)
      7'd16:   o = (v >> r) | (v << (16 - r));
      7'd24:   o = (v >> r) | (v << (24 - r));
      7'd32:   o = (v >> r) | (v << (32 - r));
      7'd48:   o = (v >> r) | (v << (48 - r));
      default: o = (v >> r) | (v << (64 - r));
    endcase
    return o & width_mask(w);
  endfunction

endpackage

@@ rtl/sbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sbc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 72
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/simon_block_cipher.sv @@
// Top level of the Simon block cipher: config registers, key schedule and round sequencer.
`timescale 1ns / 1ps

// Channel     Signals                               Handshake
// ---------   -----------------------------------   ------------------------------------
// config      cfg_we_i, cfg_idx_i, cfg_wdata_i       write at every edge with cfg_we_i high
// block in    start_i, in_i (kind/first/second)      beat taken when start_i and !busy_o
// block out   done_o, out_o (first/second)           one-cycle strobe, always taken
//
// An accepted block runs 32 to MAX_ROUNDS rounds through the single round unit; done_o
// rises the cycle after the last round and busy_o is already low then.
// Without a valid schedule a block returns zero words without running any rounds.
// A write to registers 0..4 runs the key schedule for a valid variant: a load step, then
// one round key per cycle into the key RAM, busy_o high throughout. Reset clears the
// registers and the schedule flag, not the key RAM. The receiver cannot stall results.

module simon_block_cipher
  import sbc_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 72
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  in_t                  in_i,
  output logic                 done_o,
  output out_t                 out_o
);

  localparam int unsigned AW = $clog2(MAX_ROUNDS);
  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);

  // Configuration registers
  logic [3:0]        variant_q;
  logic [WORD_W-1:0] key_q [NUM_KEYS];
  logic              cfg_hit;

  // Sequencer state
  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [5:0]        zidx_q, zidx_d;
  logic              ready_q, ready_d;
  logic              kind_q, kind_d;
  logic [WORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [WORD_W-1:0] k_q [NUM_KEYS];
  logic [WORD_W-1:0] k_d [NUM_KEYS];
  out_t              out_q, out_d;
  logic              done_q, done_d;

  // Key RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Variant-derived values
  variant_t          vinfo;
  logic [WORD_W-1:0] mask;
  logic [CW-1:0]     nrounds;
  logic [CW-1:0]     last_idx;
  logic              var_ok;

  // Datapath helpers
  logic [WORD_W-1:0] sched_t;
  logic [WORD_W-1:0] sched_top;
  logic              zbit;
  logic [WORD_W-1:0] round_x;
  logic [CW-1:0]     rd_step;
  logic              rd_kind;

  assign vinfo    = variant_info(variant_q);
  assign mask     = width_mask(vinfo.width);
  assign var_ok   = (variant_q <= LAST_VARIANT);
  assign nrounds  = (32'(vinfo.rounds) > MAX_ROUNDS) ? CW'(MAX_ROUNDS) : CW'(vinfo.rounds);
  assign last_idx = nrounds - CW'(1);

  // Writes to indexes beyond the list are dropped
  assign cfg_hit  = cfg_we_i && (cfg_idx_i <= REG_KEY3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VARIANT: variant_q <= cfg_wdata_i[3:0];
        REG_KEY0:    key_q[0]  <= cfg_wdata_i;
        REG_KEY1:    key_q[1]  <= cfg_wdata_i;
        REG_KEY2:    key_q[2]  <= cfg_wdata_i;
        REG_KEY3:    key_q[3]  <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Key schedule step: new top word from the current key words
  always_comb begin
    unique case (vinfo.kwords)
      3'd2:    sched_top = k_q[1];
      3'd3:    sched_top = k_q[2];
      default: sched_top = k_q[3];
    endcase
    zbit    = ZSEQ[vinfo.zsel][zidx_q];
    sched_t = rotr(sched_top, 3, vinfo.width);
    if (vinfo.kwords == 3'd4) begin
      sched_t = sched_t ^ k_q[1];
    end
    sched_t = sched_t ^ rotr(sched_t, 1, vinfo.width) ^ k_q[0];
    sched_t = (sched_t ^ (ROUND_CONST & mask) ^ {{(WORD_W-1){1'b0}}, zbit}) & mask;
  end

  // One Simon round on the current halves with the key read last cycle
  assign round_x = ((rotl(x_q, 1, vinfo.width) & rotl(x_q, 8, vinfo.width))
                    ^ rotl(x_q, 2, vinfo.width) ^ y_q ^ ram_rdata) & mask;

  // Read address: key for round rd_step, reversed order when decrypting
  always_comb begin
    rd_kind = (state_q == ST_IDLE) ? in_i.kind : kind_q;
    if (state_q == ST_ROUND && cnt_q != last_idx) begin
      rd_step = cnt_q + CW'(1);
    end else if (state_q == ST_ROUND) begin
      rd_step = cnt_q;
    end else begin
      rd_step = '0;
    end
    if (rd_kind) begin
      ram_raddr = AW'(last_idx - rd_step);
    end else begin
      ram_raddr = AW'(rd_step);
    end
  end

  assign ram_we    = (state_q == ST_SCHED);
  assign ram_waddr = cnt_q[AW-1:0];

  sbc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROUNDS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (k_q[0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      zidx_q  <= '0;
      ready_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      zidx_q  <= zidx_d;
      ready_q <= ready_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    out_q  <= out_d;
    for (int i = 0; i < NUM_KEYS; i++) begin
      k_q[i] <= k_d[i];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    zidx_d  = zidx_q;
    ready_d = ready_q;
    done_d  = 1'b0;
    kind_d  = kind_q;
    x_d     = x_q;
    y_d     = y_q;
    out_d   = out_q;
    for (int i = 0; i < NUM_KEYS; i++) begin
      k_d[i] = k_q[i];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (!ready_q) begin
            // No schedule: return zero words without running any rounds
            out_d  = '0;
            done_d = 1'b1;
          end else begin
            kind_d  = in_i.kind;
            x_d     = (in_i.kind ? in_i.in_first : in_i.in_second) & mask;
            y_d     = (in_i.kind ? in_i.in_second : in_i.in_first) & mask;
            cnt_d   = '0;
            state_d = ST_ROUND;
          end
        end
      end
      ST_LOAD: begin
        // Latch masked key words and clear the step counters
        for (int i = 0; i < NUM_KEYS; i++) begin
          k_d[i] = key_q[i] & mask;
        end
        cnt_d  = '0;
        zidx_d = '0;
        if (var_ok) begin
          state_d = ST_SCHED;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCHED: begin
        // Store k[0] as this round key and shift the key words down
        k_d[0] = k_q[1];
        k_d[1] = (vinfo.kwords == 3'd2) ? sched_t : k_q[2];
        k_d[2] = (vinfo.kwords == 3'd3) ? sched_t : k_q[3];
        k_d[3] = sched_t;
        zidx_d = (zidx_q == ZSEQ_LAST) ? '0 : zidx_q + 6'd1;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == last_idx) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ROUND: begin
        y_d   = x_q;
        x_d   = round_x;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == last_idx) begin
          out_d.out_first  = kind_q ? round_x : x_q;
          out_d.out_second = kind_q ? x_q : round_x;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Any write to registers 0..4 restarts the schedule
    if (cfg_hit) begin
      ready_d = 1'b0;
      state_d = ST_LOAD;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

@@ tb/simon_block_cipher_tb.sv @@
// Self-checking bench for the Simon block cipher: directed and random blocks over all variants.
`timescale 1ns / 1ps

// The bench drives the three channels of the block:
//  - config writes: only issued while the block is idle, i.e. nothing outstanding, no result
//    strobe in flight and busy_o low. Each write is followed by a settle step, so that any key
//    schedule it starts has raised busy_o before anything else is considered.
//  - block beats: start_i held until taken (start_i high and busy_o low at an edge).
//  - results: done_o strobes, always taken, checked against the oldest expected block.
// A local cipher model mirrors every register write and rebuilds its own round keys, and
// the expected output of each taken beat is worked out at the edge that takes it.

module simon_block_cipher_tb;
  import sbc_pkg::*;

  localparam int unsigned ROUND_CAP = 72;
  localparam int unsigned KEY_SLOTS = 72;
  localparam int unsigned DIRECTED_LIMIT = 500;
  localparam int unsigned CALM_TAIL = 440;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam logic [3:0] VAR_32_64   = 4'd0;
  localparam logic [3:0] VAR_96_96   = 4'd5;
  localparam logic [3:0] VAR_128_128 = 4'd7;
  localparam logic [3:0] VAR_BAD_LO  = 4'd10;
  localparam logic [3:0] VAR_BAD_HI  = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_KEY3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef enum logic [1:0] {
    ACT_BLOCK,
    ACT_WRITE,
    ACT_DRAIN
  } act_e;

  typedef struct {
    act_e                 act;
    logic                 calm;
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    wdata;
    in_t                  blk;
  } beat_t;

  typedef struct {
    int unsigned       w;
    int unsigned       n;
    int unsigned       m;
    logic [WORD_W-1:0] z;
  } shape_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [WORD_W-1:0]    cfg_wdata_i = '0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  in_t                  in_i = '0;
  logic                 done_o;
  out_t                 out_o;

  simon_block_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block's configuration and key store
  logic [3:0]        mdl_variant = '0;
  logic [WORD_W-1:0] mdl_keys [NUM_KEYS];
  logic [WORD_W-1:0] mdl_round_keys [KEY_SLOTS];
  logic              mdl_sched_ok = 1'b0;

  beat_t       beats_todo [$];
  out_t        want_blocks [$];
  int unsigned mismatches = 0;

  function automatic shape_t shape_of(input logic [3:0] v);
    shape_t s;
    case (v)
      4'd0:    s = '{16, 32, 4, 64'h19C3_522F_B386_A45F};
      4'd1:    s = '{24, 36, 3, 64'h19C3_522F_B386_A45F};
      4'd2:    s = '{24, 36, 4, 64'h1686_4FB8_AD0C_9F71};
      4'd3:    s = '{32, 42, 3, 64'h3369_F885_192C_0EF5};
      4'd4:    s = '{32, 44, 4, 64'h3C2C_E512_07A6_35DB};
      4'd5:    s = '{48, 52, 2, 64'h3369_F885_192C_0EF5};
      4'd6:    s = '{48, 54, 3, 64'h3C2C_E512_07A6_35DB};
      4'd7:    s = '{64, 68, 2, 64'h3369_F885_192C_0EF5};
      4'd8:    s = '{64, 69, 3, 64'h3C2C_E512_07A6_35DB};
      default: s = '{64, 72, 4, 64'h3DC9_4C3A_046D_678B};
    endcase
    if (s.n > ROUND_CAP) s.n = ROUND_CAP;
    return s;
  endfunction

  function automatic logic [WORD_W-1:0] word_mask(input int unsigned w);
    return (w >= WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] v, input int unsigned r,
                                            input int unsigned w);
    return ((v << r) | (v >> (w - r))) & word_mask(w);
  endfunction

  function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] v, input int unsigned r,
                                            input int unsigned w);
    return ((v >> r) | (v << (w - r))) & word_mask(w);
  endfunction

  function automatic logic [WORD_W-1:0] feistel_f(input logic [WORD_W-1:0] x,
                                                  input int unsigned w);
    return (rol(x, 1, w) & rol(x, 8, w)) ^ rol(x, 2, w);
  endfunction

  // Rebuild the round keys from the mirrored registers; invalid variants leave no schedule
  task automatic expand_key();
    shape_t            s;
    logic [WORD_W-1:0] k [NUM_KEYS];
    logic [WORD_W-1:0] mask, c, t;
    int unsigned       i, j;
    if (mdl_variant > LAST_VARIANT) begin
      mdl_sched_ok = 1'b0;
      return;
    end
    s = shape_of(mdl_variant);
    mask = word_mask(s.w);
    c = 64'hFFFF_FFFF_FFFF_FFFC & mask;
    for (i = 0; i < NUM_KEYS; i++) k[i] = mdl_keys[i] & mask;
    mdl_round_keys[0] = k[0];
    for (i = 0; i + 1 < s.n; i++) begin
      t = ror(k[s.m-1], 3, s.w);
      if (s.m == 4) t ^= k[1];
      t ^= ror(t, 1, s.w) ^ k[0];
      t ^= c ^ ((s.z >> (i % 62)) & 64'd1);
      for (j = 0; j + 1 < s.m; j++) k[j] = k[j+1];
      k[s.m-1] = t & mask;
      mdl_round_keys[i+1] = k[0];
    end
    mdl_sched_ok = 1'b1;
  endtask

  // Apply one register write to the mirror; spare indexes are dropped without a schedule run
  task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    if (idx == REG_VARIANT) begin
      mdl_variant = data[3:0];
      expand_key();
    end else if (idx <= REG_KEY3) begin
      mdl_keys[idx - REG_KEY0] = data;
      expand_key();
    end
  endtask

  function automatic out_t simon_crypt(input in_t b);
    shape_t            s;
    logic [WORD_W-1:0] mask, x, y, t;
    int unsigned       i;
    out_t              r;
    r = '0;
    if (!mdl_sched_ok) return r;
    s = shape_of(mdl_variant);
    mask = word_mask(s.w);
    if (b.kind == KIND_ENC) begin
      y = b.in_first & mask;
      x = b.in_second & mask;
      for (i = 0; i < s.n; i++) begin
        t = feistel_f(x, s.w) ^ y;
        y = x;
        x = (t ^ mdl_round_keys[i]) & mask;
      end
      r.out_first = y;
      r.out_second = x;
    end else begin
      // decrypt: swapped halves, round keys taken last to first
      x = b.in_first & mask;
      y = b.in_second & mask;
      for (i = s.n; i > 0; i--) begin
        t = feistel_f(x, s.w) ^ y;
        y = x;
        x = (t ^ mdl_round_keys[i-1]) & mask;
      end
      r.out_first = x;
      r.out_second = y;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data,
                             input logic calm);
    beat_t b;
    b = '{act: ACT_WRITE, calm: calm, idx: idx, wdata: data, blk: '0};
    beats_todo.push_back(b);
  endtask

  task automatic queue_block(input logic kind, input logic [WORD_W-1:0] first,
                             input logic [WORD_W-1:0] second, input logic calm);
    beat_t b;
    b = '{act: ACT_BLOCK, calm: calm, idx: '0, wdata: '0, blk: '0};
    b.blk.kind = kind;
    b.blk.in_first = first;
    b.blk.in_second = second;
    beats_todo.push_back(b);
  endtask

  task automatic queue_drain(input logic calm);
    beat_t b;
    b = '{act: ACT_DRAIN, calm: calm, idx: '0, wdata: '0, blk: '0};
    beats_todo.push_back(b);
  endtask

  // Driver: one decision per edge, each output gets at most one assignment per edge
  logic        took;
  logic        quiet;
  logic        settle = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = start_i && !busy_o;
      if (took) want_blocks.push_back(simon_crypt(in_i));
      // idle means nothing outstanding and no strobe being consumed at this edge
      quiet = (want_blocks.size() == 0) && !done_o;
      if (start_i && !took) begin
        // hold the beat until the block takes it
      end else if (cfg_we_i) begin
        // drop the write and set settle so the schedule can raise busy
        cfg_we_i <= 1'b0;
        settle = 1'b1;
      end else if (settle) begin
        settle = 1'b0;
        start_i <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (beats_todo.size() == 0) begin
        start_i <= 1'b0;
      end else if (!beats_todo[0].calm && $urandom_range(0, 5) == 0) begin
        // idle burst, this decision included, with gap_left drawn at random
        gap_left = $urandom_range(0, 16);
        start_i <= 1'b0;
      end else begin
        case (beats_todo[0].act)
          ACT_BLOCK: begin
            in_i <= beats_todo[0].blk;
            start_i <= 1'b1;
            void'(beats_todo.pop_front());
          end
          ACT_WRITE: begin
            start_i <= 1'b0;
            if (quiet && !busy_o) begin
              cfg_we_i <= 1'b1;
              cfg_idx_i <= beats_todo[0].idx;
              cfg_wdata_i <= beats_todo[0].wdata;
              load_register(beats_todo[0].idx, beats_todo[0].wdata);
              void'(beats_todo.pop_front());
            end
          end
          default: begin
            // hold off until every expected result is back
            start_i <= 1'b0;
            if (quiet) void'(beats_todo.pop_front());
          end
        endcase
      end
    end
  end

  // Monitor: each strobe retires the oldest expected block
  out_t want_now;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (want_blocks.size() == 0) begin
        flag_mismatch("result with nothing expected", out_o.out_first, '0);
      end else begin
        want_now = want_blocks.pop_front();
        if (out_o.out_first !== want_now.out_first)
          flag_mismatch("out_first", out_o.out_first, want_now.out_first);
        if (out_o.out_second !== want_now.out_second)
          flag_mismatch("out_second", out_o.out_second, want_now.out_second);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simon_block_cipher regression: fail");
    $finish;
  end

  initial begin
    int unsigned       nblk, cnt, j, k;
    logic              calm, var_first;
    logic [3:0]        v;
    logic [WORD_W-1:0] w;

    for (k = 0; k < NUM_KEYS; k++) mdl_keys[k] = '0;

    // Directed: no schedule yet, so both directions return zero words
    queue_block(KIND_ENC, '1, '1, 1'b1);
    queue_block(KIND_DEC, '0, '0, 1'b1);
    // A spare index must neither schedule nor disturb anything
    queue_write(REG_SPARE_LO, '1, 1'b1);
    queue_block(KIND_ENC, 64'h1234, 64'h5678, 1'b1);
    // Smallest variant with the published 32/64 known-answer key, upper bits of variant set
    queue_write(REG_VARIANT, {60'hFFF_FFFF_FFFF_FFFF, VAR_32_64}, 1'b1);
    queue_write(REG_KEY0, 64'h0100, 1'b1);
    queue_write(REG_KEY1, 64'h0908, 1'b1);
    queue_write(REG_KEY2, 64'h1110, 1'b1);
    queue_write(REG_KEY3, 64'h1918, 1'b1);
    queue_block(KIND_ENC, 64'h6877, 64'h6565, 1'b1);
    queue_block(KIND_DEC, 64'h6877, 64'h6565, 1'b1);
    queue_block(KIND_ENC, '1, '1, 1'b1);
    queue_block(KIND_DEC, '0, '0, 1'b1);
    queue_drain(1'b1);
    // Largest variant, all-ones key
    queue_write(REG_VARIANT, {60'd0, LAST_VARIANT}, 1'b1);
    for (k = 0; k < NUM_KEYS; k++) queue_write(CFG_IDX_W'(REG_KEY0 + k), '1, 1'b1);
    queue_block(KIND_ENC, '1, '1, 1'b1);
    queue_block(KIND_DEC, '1, '1, 1'b1);
    queue_block(KIND_ENC, '0, '0, 1'b1);
    queue_block(KIND_DEC, '0, '1, 1'b1);
    // Two-word key at full width
    queue_write(REG_VARIANT, {60'd0, VAR_128_128}, 1'b1);
    queue_write(REG_KEY0, 64'h0706_0504_0302_0100, 1'b1);
    queue_write(REG_KEY1, 64'h0F0E_0D0C_0B0A_0908, 1'b1);
    queue_block(KIND_ENC, 64'h6373_6564_207A_6565, 64'h6C61_7669_7571_6520, 1'b1);
    queue_block(KIND_DEC, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 1'b1);
    // Invalid variants clear the schedule: zero words until a valid one returns
    queue_write(REG_VARIANT, {60'd0, VAR_BAD_HI}, 1'b1);
    queue_block(KIND_ENC, '1, '1, 1'b1);
    queue_block(KIND_DEC, '1, '0, 1'b1);
    queue_write(REG_VARIANT, {60'hABC_DEF0_1234_5678, VAR_BAD_LO}, 1'b1);
    queue_block(KIND_ENC, 64'h0F0F, 64'hF0F0, 1'b1);
    // Back to a valid variant with an all-zero key
    queue_write(REG_VARIANT, {60'd0, VAR_96_96}, 1'b1);
    for (k = 0; k < NUM_KEYS; k++) queue_write(CFG_IDX_W'(REG_KEY0 + k), '0, 1'b1);
    queue_block(KIND_ENC, '0, '0, 1'b1);
    queue_block(KIND_DEC, '1, '1, 1'b1);

    // Random: settings, then a run of blocks under them; the tail runs without gaps
    nblk = 0;
    while (nblk < DIRECTED_LIMIT) begin
      calm = (nblk >= CALM_TAIL) || ($urandom_range(0, 2) == 0);
      var_first = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 11) == 0) v = 4'($urandom_range(VAR_BAD_LO, VAR_BAD_HI));
      else v = 4'($urandom_range(VAR_32_64, LAST_VARIANT));
      w = rand_word();
      w[3:0] = v;
      if (var_first) queue_write(REG_VARIANT, w, calm);
      for (k = 0; k < NUM_KEYS; k++)
        if ($urandom_range(0, 3) != 0) queue_write(CFG_IDX_W'(REG_KEY0 + k), rand_word(), calm);
      if (!var_first) queue_write(REG_VARIANT, w, calm);
      if ($urandom_range(0, 5) == 0)
        queue_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), rand_word(), calm);
      cnt = $urandom_range(8, 40);
      for (j = 0; j < cnt; j++) begin
        if (j == cnt / 2 && $urandom_range(0, 3) == 0) queue_drain(calm);
        queue_block(logic'($urandom_range(0, 1)), rand_word(), rand_word(), calm);
        nblk++;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_todo.size() != 0 || start_i || cfg_we_i || want_blocks.size() != 0)
      @(posedge clk_i);
    // allow a full round sequence for any late strobe
    repeat (80) @(posedge clk_i);
    if (want_blocks.size() != 0) flag_mismatch("results never arrived", '0, '0);

    if (mismatches == 0) $display("simon_block_cipher regression: pass");
    else $display("simon_block_cipher regression: fail");
    $finish;
  end

endmodule
